// ===== hw/rtl/sud_pkg.sv =====
// shared types for the signed/unsigned divider core
`default_nettype none

package sud_pkg;

    typedef struct packed {
        logic load;
        logic step;
        logic ge;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/sud_cell.sv =====
// one bit slice of the divider: remainder, quotient and divisor bits with borrow ripple
`default_nettype none

module sud_cell (
    input  wire                 i_clk,
    input  wire sud_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_load_d,
    input  wire                 i_load_q,
    input  wire                 i_r_nb,
    input  wire                 i_q_nb,
    input  wire                 i_brw,
    output logic                o_r,
    output logic                o_q,
    output logic                o_brw
);

    logic r_r;
    logic r_q;
    logic r_d;
    logic n_r;
    logic n_q;
    logic n_d;
    logic diff;

    // shifted remainder bit comes from the neighbour below
    always_comb begin
        diff  = i_r_nb ^ r_d ^ i_brw;
        o_brw = (~i_r_nb & r_d) | (~i_r_nb & i_brw) | (r_d & i_brw);
        n_r   = r_r;
        n_q   = r_q;
        n_d   = r_d;
        if (i_ctrl.load) begin
            n_r = 1'b0;
            n_q = i_load_q;
            n_d = i_load_d;
        end else if (i_ctrl.step) begin
            n_r = i_ctrl.ge ? diff : i_r_nb;
            n_q = i_q_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_q <= n_q;
        r_d <= n_d;
    end

    assign o_r = r_r;
    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_unsigned_divider_core.sv =====
// top level of the signed/unsigned divider: sign handling, sequencer and row of bit cells
// Usage:
//   input channel:  i_valid / o_stall carry one word of i_kind, i_dividend, i_divisor
//                   and i_want_remainder; a word is taken when i_valid is high and
//                   o_stall is low.
//   output channel: o_valid / i_stall carry o_result, the quotient or the remainder.
// Timing:
//   one quotient bit per cycle through the row of DATA_WIDTH bit cells: the cells load
//   the absolute values at the accepting edge, DATA_WIDTH shift/subtract steps follow,
//   then the sign fix-up into the output register, which raises o_valid.
//   one word is in the divider at a time; o_stall stays high until it has moved to
//   the output register, and only then can a new word be taken.
//   the result waits in the output register while i_stall is high; the divider
//   then holds its finished word and takes no new one until the register frees.
// Reset:
//   i_rst_n low clears the sequencer and the output valid; no result is pending after.
// Divide by zero gives quotient 0 and remainder equal to the dividend; 0/0 gives
// quotient 1 and remainder 0. Signed results wrap, so the most negative value / -1
// gives the most negative value.
`default_nettype none

module signed_unsigned_divider_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_kind,
    input  wire [DATA_WIDTH-1:0]   i_dividend,
    input  wire [DATA_WIDTH-1:0]   i_divisor,
    input  wire                    i_want_remainder,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [DATA_WIDTH-1:0]  o_result
);

    localparam int CntW = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CntW-1:0]       r_cnt;
    logic                  r_neg_q;
    logic                  r_neg_r;
    logic                  r_want_rem;
    logic                  r_den_zero;
    logic                  r_num_zero;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_result;

    logic                  in_acc;
    logic                  out_free;
    logic                  neg_a;
    logic                  neg_b;
    logic [DATA_WIDTH-1:0] abs_a;
    logic [DATA_WIDTH-1:0] abs_b;
    logic [DATA_WIDTH-1:0] r_bits;
    logic [DATA_WIDTH-1:0] q_bits;
    logic [DATA_WIDTH:0]   brw;
    logic [DATA_WIDTH-1:0] q_mag;
    logic [DATA_WIDTH-1:0] sel_mag;
    logic                  sel_neg;
    logic [DATA_WIDTH-1:0] n_result;
    sud_pkg::t_cell_ctrl   ctrl;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign neg_a = i_kind & i_dividend[DATA_WIDTH-1];
    assign neg_b = i_kind & i_divisor[DATA_WIDTH-1];
    assign abs_a = neg_a ? (~i_dividend + 1'b1) : i_dividend;
    assign abs_b = neg_b ? (~i_divisor + 1'b1) : i_divisor;

    // partial remainder may carry one bit past the word, which always means ge
    always_comb begin
        ctrl.load = in_acc;
        ctrl.step = (r_state == S_RUN);
        ctrl.ge   = r_bits[DATA_WIDTH-1] | ~brw[DATA_WIDTH];
    end

    assign brw[0] = 1'b0;

    for (genvar gi = 0; gi < DATA_WIDTH; gi++) begin : g_cell
        logic r_nb;
        logic q_nb;
        if (gi == 0) begin : g_low
            assign r_nb = q_bits[DATA_WIDTH-1];
            assign q_nb = ctrl.ge;
        end else begin : g_up
            assign r_nb = r_bits[gi-1];
            assign q_nb = q_bits[gi-1];
        end
        sud_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (ctrl),
            .i_load_d (abs_b[gi]),
            .i_load_q (abs_a[gi]),
            .i_r_nb   (r_nb),
            .i_q_nb   (q_nb),
            .i_brw    (brw[gi]),
            .o_r      (r_bits[gi]),
            .o_q      (q_bits[gi]),
            .o_brw    (brw[gi+1])
        );
    end

    // zero divisor leaves the dividend in the remainder; quotient becomes 0, or 1 for 0/0
    always_comb begin
        q_mag    = r_den_zero ? {{(DATA_WIDTH-1){1'b0}}, r_num_zero} : q_bits;
        sel_mag  = r_want_rem ? r_bits : q_mag;
        sel_neg  = r_want_rem ? r_neg_r : r_neg_q;
        n_result = sel_neg ? (~sel_mag + 1'b1) : sel_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_RUN;
                        r_cnt   <= CntW'(DATA_WIDTH - 1);
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg_q    <= neg_a ^ neg_b;
            r_neg_r    <= neg_a;
            r_want_rem <= i_want_remainder;
            r_den_zero <= (i_divisor == '0);
            r_num_zero <= (i_dividend == '0);
        end
        if (r_state == S_DONE && out_free) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##(DATA_WIDTH + 1) (r_state == S_DONE))
        else $error("divider did not finish after the expected number of steps");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == '0) |=> (r_state == S_DONE))
        else $error("step counter expired without finishing");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_den_zero) |-> (q_bits == '1))
        else $error("zero divisor did not set every quotient bit");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word appeared without a finished division");
`endif

endmodule

`default_nettype wire
